// ----- hw/rtl/dssl_pkg.sv -----
`default_nettype none
package dssl_pkg;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_MOVE   = 2'd0,
    REQ_STATUS = 2'd1,
    REQ_TICK   = 2'd2
  } req_type_t;

  // Result kinds
  localparam logic KIND_STEPS  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WINDOW_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WINDOW_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_OFFSET    = 3'd5;

  // Reset values of the configuration registers
  localparam logic        [9:0]  RST_REQUEST_OFFSET   = 10'd512;
  localparam logic signed [10:0] RST_STEP_WINDOW_LOW  = -11'sd100;
  localparam logic        [9:0]  RST_STEP_WINDOW_HIGH = 10'd100;
  localparam logic signed [9:0]  RST_POSITION_LOW     = -10'sd150;
  localparam logic        [8:0]  RST_POSITION_HIGH    = 9'd150;
  localparam logic        [9:0]  RST_REPORT_OFFSET    = 10'd800;

  // State widths
  localparam int unsigned POS_W  = 11;
  localparam int unsigned REM_W  = 12;
  localparam int unsigned REP_W  = 12;
  localparam int unsigned CALC_W = 13;

  typedef struct packed {
    logic [1:0] req_type;
    logic       motor_sel;
    logic [9:0] steps_requested;
  } in_t;

  typedef struct packed {
    logic                    result_kind;
    logic                    motor_id;
    logic signed [REP_W-1:0] position_report;
    logic                    step_first;
    logic                    dir_first;
    logic                    step_second;
    logic                    dir_second;
  } out_t;

  typedef struct packed {
    logic        [9:0]  request_offset;
    logic signed [10:0] step_window_low;
    logic        [9:0]  step_window_high;
    logic signed [9:0]  position_low;
    logic        [8:0]  position_high;
    logic        [9:0]  report_offset;
  } cfg_t;

  // Per-axis commands from the control stage
  typedef struct packed {
    logic tick;
    logic load;
  } axis_ctrl_t;

  // Per-axis status toward the result builder
  typedef struct packed {
    logic stepped;
    logic dir_now;
    logic dir_tick;
  } axis_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dual_stepper_soft_limit_controller_core.sv -----
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_data (dssl_pkg::in_t)
// out     | output    | out_valid/out_ready | out_data (dssl_pkg::out_t)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per clock unless a held result stalls: an input register, one pass of adds and
// compares, a result register. The cut path of a move sets timing.
// Reset (rst_n low, synchronous) clears positions, counts, directions and loads defaults.
// A held result stalls processing only; the input register still takes one more beat.
// Configuration beats are always accepted.
module dual_stepper_soft_limit_controller_core #(
  parameter int MOTOR_COUNT = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  dssl_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output dssl_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dssl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dssl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dssl_pkg::*;

  localparam int SecIdx = (MOTOR_COUNT > 1) ? 1 : 0;

  cfg_t cfg;

  logic in_valid_r;
  in_t  in_data_r;
  logic out_valid_r;
  out_t out_data_r, out_data_nxt;

  logic proc, has_result, sel_ok;
  logic is_move, is_status, is_tick;

  logic signed [POS_W-1:0] pos_all [MOTOR_COUNT];
  axis_stat_t              stat_all [MOTOR_COUNT];
  logic signed [POS_W-1:0] pos_sel;
  logic signed [REM_W-1:0] cut;
  logic                    hit;
  logic signed [REP_W-1:0] report;

  dssl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Decode the held item
  assign proc      = in_valid_r && (!out_valid_r || out_ready);
  assign sel_ok    = (int'(in_data_r.motor_sel) < MOTOR_COUNT);
  assign is_tick   = (in_data_r.req_type == REQ_TICK);
  assign is_move   = (in_data_r.req_type == REQ_MOVE) && sel_ok;
  assign is_status = (in_data_r.req_type == REQ_STATUS) && sel_ok;

  assign pos_sel = in_data_r.motor_sel ? pos_all[SecIdx] : pos_all[0];

  dssl_move_calc u_move (
    .steps_requested (in_data_r.steps_requested),
    .position        (pos_sel),
    .cfg             (cfg),
    .cut             (cut),
    .hit             (hit)
  );

  // One axis per motor
  for (genvar k = 0; k < MOTOR_COUNT; k++) begin : g_axis
    localparam logic KSel = (k == 1);
    axis_ctrl_t ctrl;
    assign ctrl.tick = proc && is_tick;
    assign ctrl.load = proc && is_move && (k < 2) && (in_data_r.motor_sel == KSel);
    dssl_axis u_axis (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .load_value (cut),
      .position   (pos_all[k]),
      .stat       (stat_all[k])
    );
  end

  assign report = {{(REP_W-POS_W){pos_sel[POS_W-1]}}, pos_sel}
                + $signed({{(REP_W-10){1'b0}}, cfg.report_offset});

  // Build the result beat
  always_comb begin
    has_result   = is_tick || is_status || (is_move && hit);
    out_data_nxt = '0;
    if (is_tick) begin
      out_data_nxt.result_kind = KIND_STEPS;
      out_data_nxt.step_first  = stat_all[0].stepped;
      out_data_nxt.dir_first   = stat_all[0].dir_tick;
      if (MOTOR_COUNT > 1) begin
        out_data_nxt.step_second = stat_all[SecIdx].stepped;
        out_data_nxt.dir_second  = stat_all[SecIdx].dir_tick;
      end
    end else begin
      out_data_nxt.result_kind     = KIND_REPORT;
      out_data_nxt.motor_id        = in_data_r.motor_sel;
      out_data_nxt.position_report = report;
      out_data_nxt.dir_first       = stat_all[0].dir_now;
      if (MOTOR_COUNT > 1) begin
        out_data_nxt.dir_second = stat_all[SecIdx].dir_now;
      end
    end
  end

  // Input register: take a beat when empty or draining this cycle
  assign in_ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register: load on processing, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= has_result;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && has_result) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/dssl_cfg_regs.sv -----
`default_nettype none
module dssl_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dssl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dssl_pkg::CFG_DATA_W-1:0] cfg_data,
  output dssl_pkg::cfg_t                       cfg
);
  import dssl_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Write one register per beat; unmapped indexes drop the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.request_offset   <= RST_REQUEST_OFFSET;
      cfg_r.step_window_low  <= RST_STEP_WINDOW_LOW;
      cfg_r.step_window_high <= RST_STEP_WINDOW_HIGH;
      cfg_r.position_low     <= RST_POSITION_LOW;
      cfg_r.position_high    <= RST_POSITION_HIGH;
      cfg_r.report_offset    <= RST_REPORT_OFFSET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REQUEST_OFFSET:   cfg_r.request_offset   <= cfg_data[9:0];
        CFG_STEP_WINDOW_LOW:  cfg_r.step_window_low  <= cfg_data[10:0];
        CFG_STEP_WINDOW_HIGH: cfg_r.step_window_high <= cfg_data[9:0];
        CFG_POSITION_LOW:     cfg_r.position_low     <= cfg_data[9:0];
        CFG_POSITION_HIGH:    cfg_r.position_high    <= cfg_data[8:0];
        CFG_REPORT_OFFSET:    cfg_r.report_offset    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dssl_axis.sv -----
`default_nettype none
module dssl_axis (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  dssl_pkg::axis_ctrl_t                     ctrl,
  input  wire logic signed [dssl_pkg::REM_W-1:0]   load_value,
  output logic signed [dssl_pkg::POS_W-1:0]        position,
  output dssl_pkg::axis_stat_t                     stat
);
  import dssl_pkg::*;

  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic signed [REM_W-1:0] rem_r, rem_nxt;
  logic                    dir_r, dir_nxt;
  logic                    busy;

  assign busy = (rem_r != '0);

  // Step toward zero remaining on a tick, take a new count on a move
  always_comb begin
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    dir_nxt = dir_r;
    if (ctrl.tick && busy) begin
      if (rem_r[REM_W-1]) begin
        rem_nxt = rem_r + REM_W'(1);
        pos_nxt = pos_r - POS_W'(1);
        dir_nxt = 1'b1;
      end else begin
        rem_nxt = rem_r - REM_W'(1);
        pos_nxt = pos_r + POS_W'(1);
        dir_nxt = 1'b0;
      end
    end else if (ctrl.load) begin
      rem_nxt = load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rem_r <= '0;
      dir_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      rem_r <= rem_nxt;
      dir_r <= dir_nxt;
    end
  end

  assign position      = pos_r;
  assign stat.stepped  = busy;
  assign stat.dir_now  = dir_r;
  assign stat.dir_tick = dir_nxt;

endmodule
`default_nettype wire

// ----- hw/rtl/dssl_move_calc.sv -----
`default_nettype none
module dssl_move_calc (
  input  wire logic [9:0]                         steps_requested,
  input  wire logic signed [dssl_pkg::POS_W-1:0]  position,
  input  dssl_pkg::cfg_t                          cfg,
  output logic signed [dssl_pkg::REM_W-1:0]       cut,
  output logic                                    hit
);
  import dssl_pkg::*;

  logic signed [CALC_W-1:0] cnt, cnt_hi, cnt_lim;
  logic signed [CALC_W-1:0] win_lo, win_hi, lim_lo, lim_hi, pos_x, target, cut_x;
  logic                     over, under;

  // Widen everything to a common signed width
  assign pos_x  = {{(CALC_W-POS_W){position[POS_W-1]}}, position};
  assign win_lo = {{(CALC_W-11){cfg.step_window_low[10]}}, cfg.step_window_low};
  assign win_hi = {{(CALC_W-10){1'b0}}, cfg.step_window_high};
  assign lim_lo = {{(CALC_W-10){cfg.position_low[9]}}, cfg.position_low};
  assign lim_hi = {{(CALC_W-9){1'b0}}, cfg.position_high};

  // Relative count, clamped upper bound first, then lower
  assign cnt     = $signed({{(CALC_W-10){1'b0}}, steps_requested})
                 - $signed({{(CALC_W-10){1'b0}}, cfg.request_offset});
  assign cnt_hi  = (cnt > win_hi) ? win_hi : cnt;
  assign cnt_lim = (cnt_hi < win_lo) ? win_lo : cnt_hi;

  // Cut at the soft limits; the lower limit wins when both are crossed
  assign target = pos_x + cnt_lim;
  assign over   = (target > lim_hi);
  assign under  = (target < lim_lo);

  always_comb begin
    priority if (under) begin
      cut_x = lim_lo - pos_x;
    end else if (over) begin
      cut_x = lim_hi - pos_x;
    end else begin
      cut_x = cnt_lim;
    end
  end

  assign cut = cut_x[REM_W-1:0];
  assign hit = over | under;

endmodule
`default_nettype wire

// ----- verif/tb_dual_stepper_soft_limit_controller_core.sv -----
`timescale 1ns / 100ps
module tb_dual_stepper_soft_limit_controller_core;
  import dssl_pkg::*;

  localparam int MOTORS          = 2;
  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 8;
  localparam int ITEMS_PER_PHASE = 260;
  localparam int LONG_HOLD       = 80;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Track both axes and the expected result beats in order
  class stepper_scoreboard;
    logic        [9:0]       req_off;
    logic signed [10:0]      win_lo;
    logic        [9:0]       win_hi;
    logic signed [9:0]       pos_lo;
    logic        [8:0]       pos_hi;
    logic        [9:0]       rep_off;
    logic signed [POS_W-1:0] pos [MOTORS];
    logic signed [REM_W-1:0] rem [MOTORS];
    logic                    dir_level [MOTORS];
    out_t                    awaited_results [$];
    int                      errors;

    function new();
      req_off = RST_REQUEST_OFFSET;
      win_lo  = RST_STEP_WINDOW_LOW;
      win_hi  = RST_STEP_WINDOW_HIGH;
      pos_lo  = RST_POSITION_LOW;
      pos_hi  = RST_POSITION_HIGH;
      rep_off = RST_REPORT_OFFSET;
      for (int k = 0; k < MOTORS; k++) begin
        pos[k]       = '0;
        rem[k]       = '0;
        dir_level[k] = 1'b0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_REQUEST_OFFSET:   req_off = data[9:0];
        CFG_STEP_WINDOW_LOW:  win_lo  = data[10:0];
        CFG_STEP_WINDOW_HIGH: win_hi  = data[9:0];
        CFG_POSITION_LOW:     pos_lo  = data[9:0];
        CFG_POSITION_HIGH:    pos_hi  = data[8:0];
        CFG_REPORT_OFFSET:    rep_off = data[9:0];
        default: ;
      endcase
    endfunction

    function out_t position_beat(int m);
      out_t beat;
      beat                 = '0;
      beat.result_kind     = KIND_REPORT;
      beat.motor_id        = m[0];
      beat.position_report = REP_W'(int'(pos[m]) + int'(rep_off));
      beat.dir_first       = dir_level[0];
      beat.dir_second      = dir_level[1];
      return beat;
    endfunction

    // Advance the axes for one accepted request and queue its result, if any
    function void accept_request(in_t req);
      out_t beat;
      logic stepped [MOTORS];
      int   m;
      int   cur;
      int   cnt;
      int   cut;
      bit   hit;
      beat = '0;
      m    = int'(req.motor_sel);
      cur  = int'(pos[m]);
      case (req.req_type)
        REQ_TICK: begin
          for (int k = 0; k < MOTORS; k++) begin
            stepped[k] = 1'b0;
            if (rem[k] > 0) begin
              dir_level[k] = 1'b0;
              rem[k]       = REM_W'(rem[k] - 1);
              pos[k]       = POS_W'(pos[k] + 1);
              stepped[k]   = 1'b1;
            end else if (rem[k] < 0) begin
              dir_level[k] = 1'b1;
              rem[k]       = REM_W'(rem[k] + 1);
              pos[k]       = POS_W'(pos[k] - 1);
              stepped[k]   = 1'b1;
            end
          end
          beat.result_kind = KIND_STEPS;
          beat.step_first  = stepped[0];
          beat.dir_first   = dir_level[0];
          beat.step_second = stepped[1];
          beat.dir_second  = dir_level[1];
          awaited_results.push_back(beat);
        end
        REQ_MOVE: begin
          // clamp to the step window, upper bound first
          cnt = int'(req.steps_requested) - int'(req_off);
          if (cnt > int'(win_hi)) cnt = int'(win_hi);
          if (cnt < int'(win_lo)) cnt = int'(win_lo);
          // cut at the soft limits; the lower one wins when both trip
          cut = cnt;
          hit = 1'b0;
          if (cur + cnt > int'(pos_hi)) begin
            cut = int'(pos_hi) - cur;
            hit = 1'b1;
          end
          if (cur + cnt < int'(pos_lo)) begin
            cut = int'(pos_lo) - cur;
            hit = 1'b1;
          end
          rem[m] = REM_W'(cut);
          if (hit) awaited_results.push_back(position_beat(m));
        end
        REQ_STATUS: awaited_results.push_back(position_beat(m));
        default: ;
      endcase
    endfunction

    function void check_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      check_field("result_kind", int'(want.result_kind), int'(got.result_kind));
      check_field("motor_id", int'(want.motor_id), int'(got.motor_id));
      check_field("position_report", int'($signed(want.position_report)),
                  int'($signed(got.position_report)));
      check_field("step_first", int'(want.step_first), int'(got.step_first));
      check_field("dir_first", int'(want.dir_first), int'(got.dir_first));
      check_field("step_second", int'(want.step_second), int'(got.step_second));
      check_field("dir_second", int'(want.dir_second), int'(got.dir_second));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stepper_scoreboard sb;
  bit sender_busy;
  bit receiver_busy;
  int results_seen;
  int idle_cycles;

  dual_stepper_soft_limit_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one request after a random gap and hold it until the beat
  task automatic send_request(input logic [1:0] kind, input logic motor,
                              input logic [9:0] steps);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_busy = !sender_busy;
    gap = sender_busy ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, motor_sel: motor, steps_requested: steps};
    do @(posedge clk); while (!in_ready);
    sb.accept_request(in_data);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, CFG_DATA_W'(value));
  endtask

  task automatic write_config(input int r_off, input int w_lo, input int w_hi,
                              input int p_lo, input int p_hi, input int rp_off);
    write_reg(CFG_REQUEST_OFFSET, r_off);
    write_reg(CFG_STEP_WINDOW_LOW, w_lo);
    write_reg(CFG_STEP_WINDOW_HIGH, w_hi);
    write_reg(CFG_POSITION_LOW, p_lo);
    write_reg(CFG_POSITION_HIGH, p_hi);
    write_reg(CFG_REPORT_OFFSET, rp_off);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, drain every expected beat, then idle so requests without a result pass through
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, bursts of steady ready, two long hold-offs
  initial begin
    int stall;
    while (sb == null || !rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_busy = !receiver_busy;
      if (results_seen == 400 || results_seen == 1400) stall = LONG_HOLD;
      else stall = receiver_busy ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      results_seen++;
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("dual_stepper_soft_limit_controller_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0] kind;
    logic       motor;
    logic [9:0] steps;
    int         sent;
    int         pick;
    int         near;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: reports, short moves both ways, stop, unused code
    send_request(REQ_STATUS, 1'b0, 10'd0);
    send_request(REQ_STATUS, 1'b1, 10'd0);
    send_request(REQ_MOVE, 1'b0, 10'd1023);
    send_request(REQ_TICK, 1'b0, 10'd0);
    send_request(REQ_TICK, 1'b1, 10'd1023);
    send_request(REQ_MOVE, 1'b1, 10'd0);
    send_request(REQ_TICK, 1'b0, 10'd0);
    send_request(REQ_UNUSED, 1'b1, 10'd1023);
    send_request(REQ_MOVE, 1'b0, 10'd512);
    send_request(REQ_TICK, 1'b0, 10'd0);
    send_request(REQ_STATUS, 1'b1, 10'd0);
    settle();

    // widest windows: upper limit cut on a long move
    write_config(0, -1023, 1023, -511, 511, 1023);
    send_request(REQ_MOVE, 1'b0, 10'd1023);
    send_request(REQ_TICK, 1'b0, 10'd0);
    send_request(REQ_STATUS, 1'b0, 10'd0);
    send_request(REQ_MOVE, 1'b1, 10'd0);
    settle();

    // zero-width position window: lower limit cut
    write_config(1023, -1023, 1023, 0, 0, 0);
    send_request(REQ_MOVE, 1'b1, 10'd0);
    send_request(REQ_TICK, 1'b0, 10'd0);
    settle();

    // inverted step window and inverted limits: both checks trip
    write_config(512, 40, 10, 511, 0, 0);
    send_request(REQ_MOVE, 1'b0, 10'd700);
    send_request(REQ_MOVE, 1'b1, 10'd100);
    send_request(REQ_TICK, 1'b0, 10'd0);
    settle();

    // random phases, each under its own register setting
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_config(512, -100, 100, -150, 150, 800);
        1: write_config(0, -1023, 1023, -511, 511, 1023);
        2: write_config(1023, -1023, 1023, -511, 511, 0);
        3: write_config(512, -8, 8, -20, 20, 0);
        4: write_config(512, 40, 10, 30, 10, 300);
        default: write_config($urandom_range(0, 1023), -int'($urandom_range(0, 200)),
                              $urandom_range(0, 200), -int'($urandom_range(0, 300)),
                              $urandom_range(0, 300), $urandom_range(0, 1023));
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick  = $urandom_range(0, 99);
        motor = 1'($urandom_range(0, 1));
        steps = 10'($urandom_range(0, 1023));
        if (pick < 45) begin
          kind = REQ_TICK;
        end else if (pick < 75) begin
          kind = REQ_MOVE;
          // half of the requests near the offset, so those moves stay short
          case ($urandom_range(0, 3))
            0: ;
            1: steps = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            default: begin
              near = int'(sb.req_off) + int'($urandom_range(0, 64)) - 32;
              if (near < 0) near = 0;
              if (near > 1023) near = 1023;
              steps = near[9:0];
            end
          endcase
        end else if (pick < 95) begin
          kind = REQ_STATUS;
        end else begin
          kind = REQ_UNUSED;
        end
        send_request(kind, motor, steps);
        if (kind != REQ_UNUSED) sent++;
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("dual_stepper_soft_limit_controller_core test passed");
    end else begin
      $display("dual_stepper_soft_limit_controller_core test failed");
    end
    $finish;
  end

endmodule
